/* design/nps_pkg.sv */
// Shared types, widths and codes for the nearest point search block.
package nps_pkg;

    localparam int DEF_MAX_POINTS = 1024;

    localparam int COORD_W     = 16;
    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int DIST_W      = 34;
    localparam int SQ_W        = 32;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 64;
    localparam int M_TDATA_W   = 48;

    localparam logic [DIST_W-1:0] RST_MAX_DIST_SQ  = DIST_W'(4194304);
    localparam logic [DIST_W-1:0] RST_STOP_DIST_SQ = DIST_W'(64);

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POINT_COUNT,
        REG_MAX_DIST_SQ,
        REG_STOP_DIST_SQ,
        REG_EARLY_STOP
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } scan_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic sq_valid;
        logic sum_valid;
    } dist_status_t;

endpackage

/* design/nps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/nps_dist.sv */
// Two-stage squared distance unit shared by every point of a scan.
module nps_dist #(
    parameter int IDX_W = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       flush,
    input  logic                       in_valid,
    input  logic [IDX_W-1:0]           in_idx,
    input  nps_pkg::point_t            pt,
    input  nps_pkg::point_t            query,
    output nps_pkg::dist_status_t      status,
    output logic [IDX_W-1:0]           out_idx,
    output logic [nps_pkg::DIST_W-1:0] out_dist
);

    import nps_pkg::*;

    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [COORD_W:0]     dz;
    logic signed [2*COORD_W+1:0] px;
    logic signed [2*COORD_W+1:0] py;
    logic signed [2*COORD_W+1:0] pz;

    logic                sq_valid_reg;
    logic [IDX_W-1:0]    sq_idx_reg;
    logic [SQ_W-1:0]     sq_x_reg;
    logic [SQ_W-1:0]     sq_y_reg;
    logic [SQ_W-1:0]     sq_z_reg;
    logic                sum_valid_reg;
    logic [IDX_W-1:0]    sum_idx_reg;
    logic [DIST_W-1:0]   sum_reg;

    always_comb
    begin
        dx = (COORD_W+1)'(pt.x) - (COORD_W+1)'(query.x);
        dy = (COORD_W+1)'(pt.y) - (COORD_W+1)'(query.y);
        dz = (COORD_W+1)'(pt.z) - (COORD_W+1)'(query.z);
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sq_valid_reg  <= in_valid && !flush;
            sum_valid_reg <= sq_valid_reg && !flush;
        end
    end

    // squares of 17-bit differences stay below 2^32
    always_ff @(posedge clk)
    begin
        sq_idx_reg  <= in_idx;
        sq_x_reg    <= SQ_W'(px);
        sq_y_reg    <= SQ_W'(py);
        sq_z_reg    <= SQ_W'(pz);
        sum_idx_reg <= sq_idx_reg;
        sum_reg     <= DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    end

    assign status.sq_valid  = sq_valid_reg;
    assign status.sum_valid = sum_valid_reg;
    assign out_idx          = sum_idx_reg;
    assign out_dist         = sum_reg;

endmodule

/* design/nearest_point_search_core.sv */
// Nearest point search core: point table, scan sequencer and result register.
//
// Input stream (s_*): s_tuser is the item kind, load or query. A load writes
// its coordinates into the point table at the given slot (slots at or above
// MAX_POINTS are dropped) and gives no result. A query scans slots 0 to
// point_count-1 and gives one result on the output stream (m_*): m_tuser is
// found, m_tdata holds the index and squared distance of the nearest point
// within max_dist_sq, later slot winning on a tie, both zero when none.
// With early stop enabled the scan ends at the first accepted point closer
// than stop_dist_sq.
// Flow: a load leaves the core idle. A query raises m_tvalid once its scan of
// the clamped point count n is done or it stops early at slot k, as the table
// RAM feeds one point per cycle to the distance unit. s_tready is low until
// then, so the next item is taken only after a query's result has entered its
// output register, even while the result waits there; a query finishing while
// the output is still held waits in its last step until m_tready frees it.
// Reset clears control state and the configuration registers; the point
// table is not cleared and must be loaded before it is scanned.
// Configuration writes on cfg_* take effect at once and belong in idle time.
module nearest_point_search_core #(
    parameter int MAX_POINTS = nps_pkg::DEF_MAX_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nps_pkg::S_TDATA_W-1:0] s_tdata,   // slot, x_coord, y_coord, z_coord
    input  logic                          s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nps_pkg::M_TDATA_W-1:0] m_tdata,   // best_index, best_dist_sq
    output logic                          m_tuser,   // found
    input  logic                          cfg_we,
    input  logic [nps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nps_pkg::DIST_W-1:0]    cfg_data
);

    import nps_pkg::*;

    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CMP_W-1:0] MAXP = CMP_W'(MAX_POINTS);

    // configuration
    logic [COUNT_W-1:0] point_count_reg;
    logic [DIST_W-1:0]  max_dist_sq_reg;
    logic [DIST_W-1:0]  stop_dist_sq_reg;
    logic               early_stop_reg;

    // sequencer and scan state
    scan_state_t        state_reg;
    scan_state_t        state_next;
    logic [IDX_W-1:0]   issue_idx_reg;
    logic [CNT_W-1:0]   scan_n_reg;
    point_t             query_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [DIST_W-1:0]  best_d_reg;

    // output register
    logic               m_valid_reg;
    logic               m_found_reg;
    logic [SLOT_W-1:0]  m_idx_reg;
    logic [DIST_W-1:0]  m_dist_reg;

    logic               in_fire;
    logic               in_kind;
    logic [SLOT_W-1:0]  in_slot;
    point_t             in_point;
    logic [CMP_W-1:0]   count_ext;
    logic [CNT_W-1:0]   scan_n;
    logic               slot_ok;
    logic               ram_we;
    logic [POINT_W-1:0] ram_rdata;
    logic               issue;
    logic               last_issue;
    logic               out_free;

    dist_status_t       dist_stat;
    logic [IDX_W-1:0]   dist_idx;
    logic [DIST_W-1:0]  dist_d;
    logic               upd_ok;
    logic               hit;

    always_comb
    begin
        in_fire    = s_tvalid && s_tready;
        in_kind    = s_tuser;
        in_slot    = s_tdata[SLOT_W-1:0];
        in_point.x = s_tdata[SLOT_W+COORD_W-1:SLOT_W];
        in_point.y = s_tdata[SLOT_W+2*COORD_W-1:SLOT_W+COORD_W];
        in_point.z = s_tdata[SLOT_W+3*COORD_W-1:SLOT_W+2*COORD_W];
        count_ext  = CMP_W'(point_count_reg);
        scan_n     = (count_ext > MAXP) ? CNT_W'(MAXP) : CNT_W'(count_ext);
        slot_ok    = CMP_W'(in_slot) < MAXP;
        ram_we     = in_fire && (in_kind == KIND_LOAD) && slot_ok;
        issue      = (state_reg == ST_SCAN);
        last_issue = ({1'b0, issue_idx_reg} == (scan_n_reg - CNT_W'(1)));
        out_free   = !m_valid_reg || m_tready;
        // later slot wins on equal distance
        upd_ok     = dist_stat.sum_valid && (dist_d <= max_dist_sq_reg)
                     && (!found_reg || (dist_d <= best_d_reg));
        hit        = upd_ok && early_stop_reg && (dist_d < stop_dist_sq_reg);
    end

    nps_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(in_slot)),
        .wdata (in_point),
        .raddr (issue_idx_reg),
        .rdata (ram_rdata)
    );

    nps_dist #(
        .IDX_W (IDX_W)
    ) u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .flush    (hit),
        .in_valid (rd_valid_reg),
        .in_idx   (rd_idx_reg),
        .pt       (point_t'(ram_rdata)),
        .query    (query_reg),
        .status   (dist_stat),
        .out_idx  (dist_idx),
        .out_dist (dist_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg  <= '0;
            max_dist_sq_reg  <= RST_MAX_DIST_SQ;
            stop_dist_sq_reg <= RST_STOP_DIST_SQ;
            early_stop_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_POINT_COUNT:  point_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_MAX_DIST_SQ:  max_dist_sq_reg  <= cfg_data;
                REG_STOP_DIST_SQ: stop_dist_sq_reg <= cfg_data;
                REG_EARLY_STOP:   early_stop_reg   <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_fire && (in_kind == KIND_QUERY))
                begin
                    state_next = (scan_n == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_FINISH;
                end
                else if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // the sum stage is resolved this cycle; wait for earlier stages only
                if (hit || (!rd_valid_reg && !dist_stat.sq_valid))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= issue && !hit;
            if (in_fire && (in_kind == KIND_QUERY))
            begin
                found_reg <= 1'b0;
            end
            else if (upd_ok)
            begin
                found_reg <= 1'b1;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= issue_idx_reg;
        if (in_fire && (in_kind == KIND_QUERY))
        begin
            query_reg     <= in_point;
            scan_n_reg    <= scan_n;
            issue_idx_reg <= '0;
            best_idx_reg  <= '0;
            best_d_reg    <= '0;
        end
        else
        begin
            if (issue)
            begin
                issue_idx_reg <= issue_idx_reg + IDX_W'(1);
            end
            if (upd_ok)
            begin
                best_idx_reg <= dist_idx;
                best_d_reg   <= dist_d;
            end
        end
        // best registers hold zero when nothing was found
        if ((state_reg == ST_FINISH) && out_free)
        begin
            m_found_reg <= found_reg;
            m_idx_reg   <= SLOT_W'(best_idx_reg);
            m_dist_reg  <= best_d_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = M_TDATA_W'({m_dist_reg, m_idx_reg});

`ifndef SYNTH
    a_flush_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        hit |=> !rd_valid_reg && !dist_stat.sq_valid && !dist_stat.sum_valid)
        else $error("pipeline not flushed after early stop");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> ({1'b0, issue_idx_reg} < scan_n_reg))
        else $error("scan index beyond point count");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_found_reg) |-> (m_dist_reg <= max_dist_sq_reg))
        else $error("reported point beyond maximum distance");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_found_reg) |-> (m_idx_reg == '0) && (m_dist_reg == '0))
        else $error("empty result carries nonzero fields");

    a_no_load_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN) |-> !ram_we)
        else $error("table write during scan");
`endif

endmodule

/* tb/nearest_point_search_core_tb.sv */
// Self-checking testbench for the nearest point search core: directed and random traffic.
module nearest_point_search_core_tb;
    import nps_pkg::*;

    localparam int MAX_PTS = DEF_MAX_POINTS;
    localparam int COORD_MAX = 32767;
    localparam int COORD_MIN = -32768;
    localparam int FILL_PTS = 160;
    localparam logic [DIST_W-1:0] FAR_DIST_SQ = 34'd12884508675;
    localparam int SETTLE_CYCLES = 16;
    localparam int IDLE_PCT = 13;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] index;
        logic [DIST_W-1:0] dist_sq;
    } nearest_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // slot, x_coord, y_coord, z_coord
    logic                 s_tuser;   // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // best_index, best_dist_sq
    logic                 m_tuser;   // found
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIST_W-1:0]    cfg_data;

    // Mirror of the point table and the configuration registers
    point_t              pt_mem [MAX_PTS];
    logic [COUNT_W-1:0]  reg_count;
    logic [DIST_W-1:0]   reg_max_dist;
    logic [DIST_W-1:0]   reg_stop_dist;
    logic                reg_early;

    nearest_t pending_nearest [$];
    bit       steady = 1'b0;
    int       mismatches = 0;
    int       loads_sent = 0;
    int       queries_sent = 0;
    int       results_checked = 0;

    nearest_point_search_core #(.MAX_POINTS(MAX_PTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic nearest_t nearest_point(input point_t q);
        nearest_t          best;
        int                n;
        bit                stop;
        longint            dx;
        longint            dy;
        longint            dz;
        logic [DIST_W-1:0] d;
        best = '0;
        stop = 1'b0;
        n = (reg_count > MAX_PTS) ? MAX_PTS : int'(reg_count);
        for (int i = 0; i < n && !stop; i++)
        begin
            dx = longint'(pt_mem[i].x) - longint'(q.x);
            dy = longint'(pt_mem[i].y) - longint'(q.y);
            dz = longint'(pt_mem[i].z) - longint'(q.z);
            d = DIST_W'(dx * dx + dy * dy + dz * dz);
            // later slot wins a tie, so accept on equal distance
            if ((!best.found || d <= best.dist_sq) && d <= reg_max_dist)
            begin
                best.found = 1'b1;
                best.index = SLOT_W'(i);
                best.dist_sq = d;
                if (reg_early && d < reg_stop_dist)
                    stop = 1'b1;
            end
        end
        return best;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp16(input int v);
        if (v > COORD_MAX)
            return COORD_W'(COORD_MAX);
        if (v < COORD_MIN)
            return COORD_W'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    function automatic point_t mkpt(input int x, input int y, input int z);
        return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
    endfunction

    function automatic point_t rand_pt();
        return POINT_W'({$urandom, $urandom});
    endfunction

    function automatic point_t near_pt(input point_t base, input int spread);
        point_t p;
        int     ox;
        int     oy;
        int     oz;
        ox = $urandom_range(0, 2 * spread);
        oy = $urandom_range(0, 2 * spread);
        oz = $urandom_range(0, 2 * spread);
        p.x = clamp16(int'(base.x) + ox - spread);
        p.y = clamp16(int'(base.y) + oy - spread);
        p.z = clamp16(int'(base.z) + oz - spread);
        return p;
    endfunction

    always @(posedge clk)
    begin : check_results
        nearest_t got;
        nearest_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found = m_tuser;
            got.index = m_tdata[SLOT_W-1:0];
            got.dist_sq = m_tdata[SLOT_W +: DIST_W];
            if (pending_nearest.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: found=%0b index=%0d dist_sq=%0d",
                             got.found, got.index, got.dist_sq);
            end
            else
            begin
                want = pending_nearest.pop_front();
                results_checked++;
                if (got.found !== want.found || got.index !== want.index
                    || got.dist_sq !== want.dist_sq)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch found/index/dist_sq: exp %0b/%0d/%0d got %0b/%0d/%0d",
                                 want.found, want.index, want.dist_sq,
                                 got.found, got.index, got.dist_sq);
                end
            end
        end
    end

    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot, input point_t p);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({p, slot});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind == KIND_LOAD)
        begin
            pt_mem[slot] = p;
            loads_sent++;
        end
        else
        begin
            pending_nearest.push_back(nearest_point(p));
            queries_sent++;
        end
    endtask

    task automatic hold_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_nearest.size() != 0)
            @(negedge clk);
    endtask

    // Drain results, then give a trailing load time to retire
    task automatic settle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [DIST_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POINT_COUNT:  reg_count = value[COUNT_W-1:0];
            REG_MAX_DIST_SQ:  reg_max_dist = value;
            REG_STOP_DIST_SQ: reg_stop_dist = value;
            REG_EARLY_STOP:   reg_early = value[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int count, input logic [DIST_W-1:0] max_d,
                              input logic [DIST_W-1:0] stop_d, input bit early);
        settle();
        write_reg(REG_POINT_COUNT, DIST_W'(count));
        write_reg(REG_MAX_DIST_SQ, max_d);
        write_reg(REG_STOP_DIST_SQ, stop_d);
        write_reg(REG_EARLY_STOP, DIST_W'(early));
    endtask

    // Reset values: empty scan, then the default radius boundary
    task automatic test_reset_defaults();
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(5, 5, 5));
        send_item(KIND_LOAD, SLOT_W'(0), mkpt(0, 0, 0));
        settle();
        write_reg(REG_POINT_COUNT, DIST_W'(1));
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(2048, 0, 0));
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(0, 2049, 0));
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(3, -4, 5));
    endtask

    // Corner coordinates and the largest possible distance
    task automatic test_extremes();
        send_item(KIND_LOAD, SLOT_W'(0), mkpt(COORD_MIN, COORD_MIN, COORD_MIN));
        send_item(KIND_LOAD, SLOT_W'(1), mkpt(COORD_MAX, COORD_MAX, COORD_MAX));
        set_config(2, FAR_DIST_SQ, '0, 1'b0);
        send_item(KIND_QUERY, SLOT_W'(1023), mkpt(COORD_MAX, COORD_MAX, COORD_MAX));
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(COORD_MIN, COORD_MIN, COORD_MIN));
        send_item(KIND_QUERY, SLOT_W'(512), mkpt(0, 0, 0));
        set_config(1, FAR_DIST_SQ - 1, '0, 1'b0);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(COORD_MAX, COORD_MAX, COORD_MAX));
        set_config(1, FAR_DIST_SQ, FAR_DIST_SQ, 1'b1);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(COORD_MAX, COORD_MAX, COORD_MAX));
    endtask

    // Equal distances and a zero radius
    task automatic test_tie_and_radius();
        send_item(KIND_LOAD, SLOT_W'(2), mkpt(100, -200, 300));
        send_item(KIND_LOAD, SLOT_W'(3), mkpt(100, -200, 300));
        set_config(4, FAR_DIST_SQ, '0, 1'b0);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(100, -200, 300));
        set_config(4, '0, '0, 1'b0);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(100, -200, 300));
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(101, -200, 300));
    endtask

    // Early stop at several thresholds, including none and the widest
    task automatic test_early_stop();
        send_item(KIND_LOAD, SLOT_W'(4), mkpt(1000, 0, 0));
        send_item(KIND_LOAD, SLOT_W'(5), mkpt(5, 0, 0));
        send_item(KIND_LOAD, SLOT_W'(6), mkpt(0, 1, 0));
        send_item(KIND_LOAD, SLOT_W'(7), mkpt(0, 0, 0));
        set_config(8, FAR_DIST_SQ, DIST_W'(64), 1'b1);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(0, 0, 0));
        set_config(8, FAR_DIST_SQ, '0, 1'b1);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(0, 0, 0));
        set_config(8, FAR_DIST_SQ, DIST_W'(25), 1'b1);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(0, 0, 0));
        set_config(8, FAR_DIST_SQ, FAR_DIST_SQ, 1'b1);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(0, 0, 0));
        set_config(8, FAR_DIST_SQ, DIST_W'(64), 1'b0);
        send_item(KIND_QUERY, SLOT_W'(0), mkpt(0, 0, 0));
    endtask

    // Fill a block of slots, then scan all of it with wide and tight settings
    task automatic test_full_table();
        for (int s = 0; s < FILL_PTS; s++)
            send_item(KIND_LOAD, SLOT_W'(s), rand_pt());
        set_config(FILL_PTS, FAR_DIST_SQ, '0, 1'b0);
        repeat (3) send_item(KIND_QUERY, SLOT_W'($urandom), rand_pt());
        set_config(FILL_PTS, DIST_W'($urandom_range(0, 1 << 30)),
                   DIST_W'($urandom_range(0, 1 << 24)), 1'b1);
        repeat (2) send_item(KIND_QUERY, SLOT_W'($urandom), near_pt(pt_mem[FILL_PTS - 1], 500));
    endtask

    task automatic test_random(input int phases, input int per_phase);
        int                n;
        int                span;
        int                pick;
        logic [DIST_W-1:0] max_d;
        logic [DIST_W-1:0] stop_d;
        logic [SLOT_W-1:0] slot;
        point_t            p;
        for (int ph = 0; ph < phases; ph++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                n = $urandom_range(1, 48);
            else if (pick < 95)
                n = $urandom_range(49, FILL_PTS - 3);
            else
                n = $urandom_range(FILL_PTS - 2, FILL_PTS);
            case ($urandom_range(0, 3))
                0: max_d = FAR_DIST_SQ;
                1: max_d = DIST_W'($urandom_range(0, 1 << 20));
                2:
                begin
                    max_d = DIST_W'({$urandom, $urandom});
                    if (max_d > FAR_DIST_SQ)
                        max_d = max_d - FAR_DIST_SQ;
                end
                default: max_d = DIST_W'($urandom_range(0, 1 << 30));
            endcase
            case ($urandom_range(0, 3))
                0: stop_d = '0;
                1: stop_d = DIST_W'($urandom_range(0, 4096));
                2: stop_d = FAR_DIST_SQ;
                default: stop_d = DIST_W'($urandom_range(0, 1 << 16));
            endcase
            // one phase runs with no idling on either side
            steady = (ph == phases / 2);
            set_config(n, max_d, stop_d, 1'($urandom_range(0, 1)));
            span = (n > MAX_PTS) ? MAX_PTS : n;
            for (int k = 0; k < per_phase; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                    hold_for_results();
                pick = $urandom_range(0, 99);
                if (pick < 35)
                begin
                    slot = (pick < 25) ? SLOT_W'($urandom_range(0, span - 1)) : SLOT_W'($urandom);
                    if (pick < 8)
                        p = pt_mem[$urandom_range(0, span - 1)];
                    else if (pick < 20)
                        p = near_pt(pt_mem[$urandom_range(0, span - 1)], 200);
                    else
                        p = rand_pt();
                    send_item(KIND_LOAD, slot, p);
                end
                else
                begin
                    if (pick < 55)
                        p = rand_pt();
                    else if (pick < 70)
                        p = pt_mem[$urandom_range(0, span - 1)];
                    else
                        p = near_pt(pt_mem[$urandom_range(0, span - 1)], 64);
                    send_item(KIND_QUERY, SLOT_W'($urandom), p);
                end
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_LOAD;
        cfg_we    = 1'b0;
        cfg_index = REG_POINT_COUNT;
        cfg_data  = '0;
        reg_count     = '0;
        reg_max_dist  = RST_MAX_DIST_SQ;
        reg_stop_dist = RST_STOP_DIST_SQ;
        reg_early     = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_extremes();
        test_tie_and_radius();
        test_early_stop();
        test_full_table();
        test_random(14, 28);
        settle();

        $display("Sent %0d point loads and %0d nearest point queries, checked %0d results,",
                 loads_sent, queries_sent, results_checked);
        $display("with point counts from 0 to %0d, radius and early stop settings at their limits.",
                 FILL_PTS);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
